>>> src/dtr_pkg.sv
package dtr_pkg;

	localparam int DivW     = 16;
	localparam int CntW     = 8;
	localparam int TickW    = 8;
	localparam int RelW     = 8;
	localparam int CtlW     = 3;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 8;

	localparam logic [CfgIdxW-1:0] REG_RELOAD  = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_CONTROL = 1'd1;

	localparam logic [1:0]      TAP_SEL_MASK = 2'b11;
	localparam logic [DivW-1:0] TAP_MASK0    = 16'h0200;
	localparam logic [DivW-1:0] TAP_MASK1    = 16'h0008;
	localparam logic [DivW-1:0] TAP_MASK2    = 16'h0020;
	localparam logic [DivW-1:0] TAP_MASK3    = 16'h0080;
	localparam logic [CtlW-1:0] ENABLE_MASK  = 3'b100;

	localparam logic FUNC_ADVANCE = 1'b0;
	localparam logic FUNC_RESET   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_RESET_DIV,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic tick;
		logic reset_div;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ticks_done;
		logic out_free;
	} dp_status_t;

	function automatic logic tap_signal(input logic [DivW-1:0] div,
			input logic [CtlW-1:0] ctl);
		logic [DivW-1:0] mask;
		begin
			case (ctl[1:0] & TAP_SEL_MASK)
				2'd0: mask = TAP_MASK0;
				2'd1: mask = TAP_MASK1;
				2'd2: mask = TAP_MASK2;
				2'd3: mask = TAP_MASK3;
				default: mask = TAP_MASK0;
			endcase
			tap_signal = ((div & mask) != '0) && ((ctl & ENABLE_MASK) != '0);
		end
	endfunction

endpackage

>>> src/dtr_if.sv
interface dtr_req_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [dtr_pkg::TickW-1:0] tick_count;

	modport source (output valid, output func, output tick_count, input ready);
	modport sink (input valid, input func, input tick_count, output ready);
endinterface

interface dtr_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [7:0]               divider_high;
	logic [dtr_pkg::CntW-1:0] counter_value;
	logic                     overflow_irq;

	modport source (output valid, output divider_high, output counter_value,
		output overflow_irq, input ready);
	modport sink (input valid, input divider_high, input counter_value,
		input overflow_irq, output ready);
endinterface

>>> src/dtr_ctrl.sv
module dtr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_func,
	input  logic [dtr_pkg::TickW-1:0] req_ticks,
	output logic                req_ready,
	input  dtr_pkg::dp_status_t status,
	output dtr_pkg::dp_cmd_t    cmd
);

	dtr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		req_ready     = 1'b0;
		cmd           = '0;
		case (state_q)
			dtr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					if (req_func == dtr_pkg::FUNC_RESET) begin
						state_d = dtr_pkg::ST_RESET_DIV;
					end else if (req_ticks == '0) begin
						state_d = dtr_pkg::ST_FINISH;
					end else begin
						state_d = dtr_pkg::ST_RUN;
					end
				end
			end
			dtr_pkg::ST_RUN: begin
				// one machine tick per cycle until the count runs out
				cmd.tick = 1'b1;
				if (status.ticks_done) begin
					state_d = dtr_pkg::ST_FINISH;
				end
			end
			dtr_pkg::ST_RESET_DIV: begin
				cmd.reset_div = 1'b1;
				state_d       = dtr_pkg::ST_FINISH;
			end
			dtr_pkg::ST_FINISH: begin
				// hold until the output register can take the item
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = dtr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dtr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/dtr_datapath.sv
module dtr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dtr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [dtr_pkg::CfgDataW-1:0]  cfg_data,
	input  logic [dtr_pkg::TickW-1:0]     req_ticks,
	input  dtr_pkg::dp_cmd_t              cmd,
	output dtr_pkg::dp_status_t           status,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [7:0]                    rsp_divider_high,
	output logic [dtr_pkg::CntW-1:0]      rsp_counter_value,
	output logic                          rsp_overflow_irq
);

	logic [dtr_pkg::RelW-1:0]  reload_q;
	logic [dtr_pkg::CtlW-1:0]  control_q;
	logic [dtr_pkg::DivW-1:0]  divider_q;
	logic [dtr_pkg::CntW-1:0]  counter_q;
	logic                      prev_tap_q;
	logic                      irq_q;
	logic [dtr_pkg::TickW-1:0] remain_q;
	logic                      out_valid_q;
	logic [7:0]                out_div_q;
	logic [dtr_pkg::CntW-1:0]  out_cnt_q;
	logic                      out_irq_q;

	logic [dtr_pkg::DivW-1:0]  div_next;
	logic                      tap_now;
	logic                      fall;
	logic                      step;

	assign div_next = cmd.reset_div ? '0 : divider_q + dtr_pkg::DivW'(1);
	assign tap_now  = dtr_pkg::tap_signal(div_next, control_q);
	assign fall     = prev_tap_q && !tap_now;
	assign step     = cmd.tick || cmd.reset_div;

	assign status.ticks_done = (remain_q == dtr_pkg::TickW'(1));
	assign status.out_free   = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q   <= '0;
			control_q  <= '0;
			divider_q  <= '0;
			counter_q  <= '0;
			prev_tap_q <= 1'b0;
			irq_q      <= 1'b0;
			remain_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dtr_pkg::REG_RELOAD:  reload_q  <= cfg_data[dtr_pkg::RelW-1:0];
					dtr_pkg::REG_CONTROL: control_q <= cfg_data[dtr_pkg::CtlW-1:0];
					default: ;
				endcase
			end
			if (cmd.start) begin
				remain_q <= req_ticks;
				irq_q    <= 1'b0;
			end
			if (step) begin
				divider_q  <= div_next;
				prev_tap_q <= tap_now;
				if (fall) begin
					if (counter_q == '1) begin
						counter_q <= reload_q;
						irq_q     <= 1'b1;
					end else begin
						counter_q <= counter_q + dtr_pkg::CntW'(1);
					end
				end
			end
			if (cmd.tick) begin
				remain_q <= remain_q - dtr_pkg::TickW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_div_q <= divider_q[dtr_pkg::DivW-1:8];
			out_cnt_q <= counter_q;
			out_irq_q <= irq_q;
		end
	end

	assign rsp_valid         = out_valid_q;
	assign rsp_divider_high  = out_div_q;
	assign rsp_counter_value = out_cnt_q;
	assign rsp_overflow_irq  = out_irq_q;

endmodule

>>> src/divider_timer_with_reload_top.sv
// Divider and timer counter with reload.
// req channel: one item either resets the 16-bit divider (func = 1) or
// advances it by tick_count machine ticks (func = 0). Each tick bumps the
// divider; the selected divider bit ANDed with the enable bit is watched for
// a one-to-zero transition, which steps the 8-bit counter. On overflow the
// counter reloads from reload_value and the item's overflow_irq is set.
// rsp channel: one item per request with divider bits 15:8, the counter and
// the overflow flag.
// Config: cfg_we/cfg_index/cfg_data; index 0 reload_value, 1 timer_control.
// Write only while the block is idle.
// Sequence: an advance is accepted, then runs one tick per cycle in the step
// loop and finishes with the output load; a zero-tick advance goes from accept
// straight to the output load, and a divider reset passes through the reset
// step before it. rsp.valid rises once the output register is loaded.
// A finished result sits in an output register; the next item is accepted
// meanwhile, but while rsp stalls its result is held in the datapath with the
// controller parked and req.ready low until the output register frees.
// Reset (arst_n low) clears divider, counter, stored tap, both registers and
// the output valid flag.
module divider_timer_with_reload_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dtr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dtr_pkg::CfgDataW-1:0] cfg_data,
	dtr_req_if.sink                      req,
	dtr_rsp_if.source                    rsp
);

	dtr_pkg::dp_cmd_t    cmd;
	dtr_pkg::dp_status_t status;

	dtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ticks (req.tick_count),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	dtr_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.req_ticks         (req.tick_count),
		.cmd               (cmd),
		.status            (status),
		.rsp_ready         (rsp.ready),
		.rsp_valid         (rsp.valid),
		.rsp_divider_high  (rsp.divider_high),
		.rsp_counter_value (rsp.counter_value),
		.rsp_overflow_irq  (rsp.overflow_irq)
	);

endmodule

>>> verif/dtr_checker.sv
`timescale 1ns / 1ps

module dtr_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dtr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dtr_pkg::CfgDataW-1:0] cfg_data,
	dtr_req_if                           req,
	dtr_rsp_if                           rsp,
	output int                           mismatches,
	output int                           outstanding
);
	import dtr_pkg::*;

	typedef struct packed {
		logic [7:0]      div_high;
		logic [CntW-1:0] count;
		logic            irq;
	} timer_result_t;

	logic [DivW-1:0] div_q;
	logic [CntW-1:0] cnt_q;
	logic            tap_q;
	logic [RelW-1:0] reload_q;
	logic [CtlW-1:0] ctl_q;

	timer_result_t results_q[$];
	timer_result_t want;
	int            fail_tally = 0;
	int            depth = 0;

	assign mismatches  = fail_tally;
	assign outstanding = depth;

	task automatic note_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		fail_tally++;
	endtask

	function automatic logic tap_now();
		logic [DivW-1:0] sel;
		case (ctl_q[1:0] & TAP_SEL_MASK)
			2'd0: sel = TAP_MASK0;
			2'd1: sel = TAP_MASK1;
			2'd2: sel = TAP_MASK2;
			default: sel = TAP_MASK3;
		endcase
		return ((div_q & sel) != '0) && ((ctl_q & ENABLE_MASK) != '0);
	endfunction

	// step the counter on a falling tap, reload on wrap
	function automatic logic sample_tap_edge();
		logic level;
		logic wrapped;
		level = tap_now();
		wrapped = 1'b0;
		if (tap_q && !level) begin
			if (cnt_q == '1) begin
				cnt_q = reload_q;
				wrapped = 1'b1;
			end else begin
				cnt_q = cnt_q + 1'b1;
			end
		end
		tap_q = level;
		return wrapped;
	endfunction

	function automatic timer_result_t run_item(input logic fn, input logic [TickW-1:0] n);
		timer_result_t r;
		logic          hit;
		int            k;
		hit = 1'b0;
		if (fn == FUNC_RESET) begin
			div_q = '0;
			hit = sample_tap_edge();
		end else begin
			for (k = 0; k < n; k++) begin
				div_q = div_q + 1'b1;
				if (sample_tap_edge())
					hit = 1'b1;
			end
		end
		r.div_high = div_q[DivW-1:8];
		r.count    = cnt_q;
		r.irq      = hit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q    = '0;
			cnt_q    = '0;
			tap_q    = 1'b0;
			reload_q = '0;
			ctl_q    = '0;
			results_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RELOAD:  reload_q = cfg_data[RelW-1:0];
					REG_CONTROL: ctl_q = cfg_data[CtlW-1:0];
					default: ;
				endcase
			end
			// results belong to earlier items, so retire before predicting
			if (rsp.valid && rsp.ready) begin
				if (results_q.size() == 0) begin
					note_mismatch($sformatf("unexpected item: div_high %0h counter %0h irq %0b",
						rsp.divider_high, rsp.counter_value, rsp.overflow_irq));
				end else begin
					want = results_q.pop_front();
					if (rsp.divider_high !== want.div_high)
						note_mismatch($sformatf("divider_high got %0h want %0h",
							rsp.divider_high, want.div_high));
					if (rsp.counter_value !== want.count)
						note_mismatch($sformatf("counter_value got %0h want %0h",
							rsp.counter_value, want.count));
					if (rsp.overflow_irq !== want.irq)
						note_mismatch($sformatf("overflow_irq got %0b want %0b",
							rsp.overflow_irq, want.irq));
				end
			end
			if (req.valid && req.ready)
				results_q.push_back(run_item(req.func, req.tick_count));
		end
		depth = results_q.size();
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import dtr_pkg::*;

	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 800;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 120;
	localparam int SETTLE      = 260;
	localparam int TIMEOUT_NS  = 9_000_000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	int                  mismatches;
	int                  outstanding;
	int                  req_sent = 0;
	int                  rsp_seen = 0;

	dtr_req_if req_ch ();
	dtr_rsp_if rsp_ch ();

	divider_timer_with_reload_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	dtr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// every fourth stretch of 40 items runs with no idling
	function automatic int draw_gap(input int seq);
		if ((seq / 40) % 4 == 3)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_item(input logic fn, input logic [TickW-1:0] n);
		int gap;
		gap = draw_gap(req_sent);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.func       <= fn;
		req_ch.tick_count <= n;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		req_sent++;
	endtask

	task automatic random_item();
		logic             fn;
		logic [TickW-1:0] n;
		int               pick;
		fn = ($urandom_range(0, 9) == 0) ? FUNC_RESET : FUNC_ADVANCE;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			n = TickW'($urandom_range(0, 15));
		else if (pick < 6)
			n = '1;
		else
			n = TickW'($urandom_range(0, 255));
		send_item(fn, n);
	endtask

	// drop valid and hold until every item has come back
	task automatic finish_phase();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(rsp_seen);
			@(negedge clk);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			rsp_seen++;
			// long hold so the block backs up into its input
			if (rsp_seen == HOLD_AT) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int              ph;
		logic [CfgDataW-1:0] ctl_val;
		req_ch.valid      = 1'b0;
		req_ch.func       = FUNC_ADVANCE;
		req_ch.tick_count = '0;
		cfg_we            = 1'b0;
		cfg_index         = REG_RELOAD;
		cfg_data          = '0;
		arst_n            = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// enabled, tap on bit 3; reload of all ones wraps on every edge after overflow
		write_reg(REG_RELOAD, 8'hFF);
		write_reg(REG_CONTROL, CfgDataW'(ENABLE_MASK | 3'd1));
		send_item(FUNC_ADVANCE, '0);
		send_item(FUNC_ADVANCE, 8'd8);
		// divider reset with tap high steps the counter
		send_item(FUNC_RESET, 8'hFF);
		repeat (17) send_item(FUNC_ADVANCE, 8'hFF);
		send_item(FUNC_RESET, '0);
		send_item(FUNC_ADVANCE, 8'd8);
		finish_phase();
		// moving the tap to bit 9 drops the signal; the next tick sees the edge
		write_reg(REG_CONTROL, CfgDataW'(ENABLE_MASK));
		send_item(FUNC_ADVANCE, 8'd1);
		finish_phase();

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_RELOAD, '0);
					write_reg(REG_CONTROL, '0);
				end
				1: begin
					write_reg(REG_RELOAD, '1);
					write_reg(REG_CONTROL, '1);
				end
				default: begin
					if (ph % 2 == 1)
						write_reg(REG_RELOAD, CfgDataW'($urandom_range(240, 255)));
					else
						write_reg(REG_RELOAD, CfgDataW'($urandom_range(0, 255)));
					ctl_val = CfgDataW'($urandom_range(0, 255));
					if (ph % 3 != 0)
						ctl_val = ctl_val | CfgDataW'(ENABLE_MASK);
					write_reg(REG_CONTROL, ctl_val);
				end
			endcase
			repeat (PHASE_ITEMS) random_item();
			finish_phase();
		end

		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
src/dtr_pkg.sv
src/dtr_if.sv
src/dtr_ctrl.sv
src/dtr_datapath.sv
src/divider_timer_with_reload_top.sv
verif/dtr_checker.sv
verif/tb_top.sv
